// ===== rtl/pre_pkg.sv =====
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants for the page replacement engine
// frame record layout, outcome and policy codes, sequencer states
// ----------------------------------------------------------------------------
`default_nettype none
package pre_pkg;
  localparam int unsigned FRAMES     = 64;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned FIDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FCNT_W     = $clog2(FRAMES + 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0, POL_LRU = 2'd1, POL_CLOCK = 2'd2, POL_PLRU = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    OUT_HIT = 2'd0, OUT_LOAD = 2'd1, OUT_REPLACE = 2'd2, OUT_FAIL = 2'd3
  } outcome_t;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;

  typedef struct packed {
    logic [7:0]            owner;
    logic [15:0]           page;
    logic [STAMP_BITS-1:0] stamp;
    logic                  refbit;
    logic                  touched;
  } frame_t;

  // memory access request from sequencer to frame store
  typedef struct packed {
    logic              rd_en;
    logic [FIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [FIDX_W-1:0] wr_addr;
    frame_t            wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HIT_RD, ST_HIT_CHK, ST_DECIDE, ST_FIFO_CHK, ST_CLK_CHK,
    ST_LRU_CHK, ST_REPL_RD, ST_REPL_WR, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/pre_frame_ram.sv =====
// ----------------------------------------------------------------------------
// pre_frame_ram: frame record store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module pre_frame_ram
  import pre_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output frame_t        rd_data
);
  frame_t mem [FRAMES];
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      // a write to the same entry in the same cycle is seen by the read
      if (req.wr_en && req.wr_addr == req.rd_addr) begin
        rd_data <= req.wr_data;
      end else begin
        rd_data <= mem[req.rd_addr];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pre_seq.sv =====
// ----------------------------------------------------------------------------
// pre_seq: access sequencer
// hit scan, fill, and victim searches as read-modify-write sweeps of the store
// ----------------------------------------------------------------------------
`default_nettype none
module pre_seq
  import pre_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire policy_t           policy,
  input  wire logic [6:0]        frames_cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_process_id,
  input  wire logic [15:0]       in_page_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_outcome,
  output logic [5:0]             out_frame_index,
  output mem_req_t               req,
  input  wire frame_t            rd_data
);
  state_t state_r, state_nxt;
  logic [7:0]            pid_r;
  logic [15:0]           pg_r;
  logic [FCNT_W-1:0]     fill_r, fill_nxt;
  logic [FIDX_W-1:0]     fifo_r, fifo_nxt;
  logic [FIDX_W-1:0]     clk_r, clk_nxt;
  logic [STAMP_BITS-1:0] cnt_r, cnt_nxt;
  logic [FCNT_W-1:0]     m_r;
  logic [FCNT_W-1:0]     live_r;
  logic [FCNT_W-1:0]     i_r, i_nxt;   // sweep index
  logic [FCNT_W-1:0]     g_r, g_nxt;   // visits in fifo/clock sweep
  logic                  hit_r, hit_nxt;
  logic [FIDX_W-1:0]     idx_r, idx_nxt;
  // lru candidates: any-unpinned min, other-process min, any-unpinned max
  logic                  a_ok_r, a_ok_nxt, o_ok_r, o_ok_nxt, s_ok_r, s_ok_nxt;
  logic [FIDX_W-1:0]     a_idx_r, a_idx_nxt, o_idx_r, o_idx_nxt, s_idx_r, s_idx_nxt;
  logic [STAMP_BITS-1:0] a_st_r, a_st_nxt, o_st_r, o_st_nxt, s_st_r, s_st_nxt;
  logic                  pend_r, pend_nxt;  // a read is in flight for i_r-1
  logic [FIDX_W-1:0]     pa_r, pa_nxt;      // address of that read
  logic                  ovalid_r, ovalid_nxt;
  outcome_t              oout_r, oout_nxt;
  logic [FIDX_W-1:0]     oidx_r, oidx_nxt;
  logic [FCNT_W-1:0]     m_c;
  logic [STAMP_BITS-1:0] cnt_inc;
  logic [FIDX_W-1:0]     wrap_c;
  logic                  restamp_r, restamp_nxt;
  logic                  setref_r, setref_nxt;
  logic                  srch_done;
  state_t                srch_to;

  always_comb begin
    if (frames_cfg == 7'd0) begin
      m_c = FCNT_W'(1);
    end else if ({{(32-7){1'b0}}, frames_cfg} > 32'(FRAMES)) begin
      m_c = FCNT_W'(FRAMES);
    end else begin
      m_c = FCNT_W'(frames_cfg);
    end
  end

  assign cnt_inc = (cnt_r == STAMP_MAX) ? cnt_r : cnt_r + 1'b1;

  function automatic logic [FIDX_W-1:0] nxt_ptr(logic [FIDX_W-1:0] p,
                                                 logic [FCNT_W-1:0] m);
    logic [FCNT_W-1:0] q;
    q = FCNT_W'(p) + 1'b1;
    return (q >= m) ? '0 : q[FIDX_W-1:0];
  endfunction

  assign wrap_c = '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid && !ovalid_r) state_nxt = ST_HIT_RD;
      ST_HIT_RD:  state_nxt = ST_HIT_CHK;
      ST_HIT_CHK: if (!pend_r && i_r >= live_r) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        priority if (hit_r || fill_r < m_r) state_nxt = ST_DONE;
        else if (policy == POL_FIFO)       state_nxt = ST_FIFO_CHK;
        else if (policy == POL_CLOCK)      state_nxt = ST_CLK_CHK;
        else                               state_nxt = ST_LRU_CHK;
      end
      // search states leave through the datapath block's decision
      ST_FIFO_CHK, ST_CLK_CHK, ST_LRU_CHK: if (srch_done) state_nxt = srch_to;
      ST_REPL_RD: state_nxt = ST_REPL_WR;
      ST_REPL_WR: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_nxt = fill_r; fifo_nxt = fifo_r; clk_nxt = clk_r; cnt_nxt = cnt_r;
    i_nxt = i_r; g_nxt = g_r; hit_nxt = hit_r; idx_nxt = idx_r;
    a_ok_nxt = a_ok_r; a_idx_nxt = a_idx_r; a_st_nxt = a_st_r;
    o_ok_nxt = o_ok_r; o_idx_nxt = o_idx_r; o_st_nxt = o_st_r;
    s_ok_nxt = s_ok_r; s_idx_nxt = s_idx_r; s_st_nxt = s_st_r;
    pend_nxt = 1'b0; pa_nxt = pa_r;
    ovalid_nxt = ovalid_r; oout_nxt = oout_r; oidx_nxt = oidx_r;
    restamp_nxt = restamp_r; setref_nxt = setref_r;
    srch_done = 1'b0; srch_to = ST_DONE;
    req = '0;
    req.wr_data = rd_data;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0; hit_nxt = 1'b0; idx_nxt = '0;
      end
      ST_HIT_RD, ST_HIT_CHK: begin
        // pipelined scan: read i, check the frame read last cycle
        if (pend_r) begin
          if (rd_data.owner == pid_r && rd_data.page == pg_r) begin
            req.wr_en   = 1'b1;
            req.wr_addr = pa_r;
            req.wr_data.stamp   = cnt_r;
            req.wr_data.refbit  = 1'b1;
            req.wr_data.touched = 1'b1;
            cnt_nxt = cnt_inc;
            if (!hit_r) idx_nxt = pa_r;
            hit_nxt = 1'b1;
          end
        end
        if (i_r < live_r) begin
          req.rd_en   = 1'b1;
          req.rd_addr = i_r[FIDX_W-1:0];
          pend_nxt = 1'b1;
          pa_nxt   = i_r[FIDX_W-1:0];
          i_nxt    = i_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        g_nxt = '0; i_nxt = '0;
        a_ok_nxt = 1'b0; o_ok_nxt = 1'b0; s_ok_nxt = 1'b0;
        if (hit_r) begin
          oout_nxt = OUT_HIT; oidx_nxt = idx_r;
        end else if (fill_r < m_r) begin
          req.wr_en = 1'b1;
          req.wr_addr = fill_r[FIDX_W-1:0];
          req.wr_data.owner = pid_r; req.wr_data.page = pg_r;
          req.wr_data.stamp = cnt_r; req.wr_data.refbit = 1'b1;
          req.wr_data.touched = 1'b0;
          cnt_nxt = cnt_inc;
          fill_nxt = fill_r + 1'b1;
          oout_nxt = OUT_LOAD; oidx_nxt = fill_r[FIDX_W-1:0];
        end else begin
          if (FCNT_W'(fifo_r) >= m_r) fifo_nxt = '0;
          if (FCNT_W'(clk_r) >= m_r)  clk_nxt = '0;
          req.rd_en = 1'b1;
          if (policy == POL_FIFO) begin
            req.rd_addr = (FCNT_W'(fifo_r) >= m_r) ? wrap_c : fifo_r;
          end else if (policy == POL_CLOCK) begin
            req.rd_addr = (FCNT_W'(clk_r) >= m_r) ? wrap_c : clk_r;
          end else begin
            req.rd_addr = '0;
            i_nxt = FCNT_W'(1);
          end
          pa_nxt = req.rd_addr;
        end
      end
      ST_FIFO_CHK: begin
        // rd_data is frame at fifo_r
        if (rd_data.touched) begin
          idx_nxt = fifo_r; fifo_nxt = nxt_ptr(fifo_r, m_r);
          restamp_nxt = 1'b0; setref_nxt = 1'b0;
          srch_done = 1'b1; srch_to = ST_REPL_WR;
        end else if (g_r + 1'b1 == m_r) begin
          fifo_nxt = nxt_ptr(fifo_r, m_r);
          oout_nxt = OUT_FAIL; oidx_nxt = '0;
          srch_done = 1'b1; srch_to = ST_DONE;
        end else begin
          fifo_nxt = nxt_ptr(fifo_r, m_r);
          g_nxt = g_r + 1'b1;
          req.rd_en = 1'b1; req.rd_addr = nxt_ptr(fifo_r, m_r);
        end
        // failed sweep leaves pointer where it began: m steps wrap fully
      end
      ST_CLK_CHK: begin
        if (!rd_data.refbit && rd_data.touched) begin
          idx_nxt = clk_r; clk_nxt = nxt_ptr(clk_r, m_r);
          restamp_nxt = 1'b0; setref_nxt = 1'b1;
          srch_done = 1'b1; srch_to = ST_REPL_WR;
        end else begin
          // clear the reference bit in place
          req.wr_en = 1'b1; req.wr_addr = clk_r;
          req.wr_data.refbit = 1'b0;
          if (!rd_data.touched) s_st_nxt = s_st_r + 1'b1;
          g_nxt = g_r + 1'b1;
          if (g_r + 1'b1 == m_r && s_st_r + 1'b1 == STAMP_BITS'(g_r + 1'b1) &&
              !rd_data.touched) begin
            oout_nxt = OUT_FAIL; oidx_nxt = '0;
            srch_done = 1'b1; srch_to = ST_DONE;
          end else begin
            clk_nxt = nxt_ptr(clk_r, m_r);
            req.rd_en = 1'b1; req.rd_addr = nxt_ptr(clk_r, m_r);
          end
        end
      end
      ST_LRU_CHK: begin
        // rd_data is frame pa_r
        if (rd_data.touched) begin
          if (!a_ok_r || rd_data.stamp < a_st_r) begin
            a_ok_nxt = 1'b1; a_idx_nxt = pa_r; a_st_nxt = rd_data.stamp;
          end
          if (rd_data.owner != pid_r) begin
            if (!o_ok_r || rd_data.stamp < o_st_r) begin
              o_ok_nxt = 1'b1; o_idx_nxt = pa_r; o_st_nxt = rd_data.stamp;
            end
          end
          if (!s_ok_r || rd_data.stamp > s_st_r) begin
            s_ok_nxt = 1'b1; s_idx_nxt = pa_r; s_st_nxt = rd_data.stamp;
          end
        end
        if (i_r < m_r) begin
          req.rd_en = 1'b1; req.rd_addr = i_r[FIDX_W-1:0];
          pa_nxt = i_r[FIDX_W-1:0]; i_nxt = i_r + 1'b1;
        end else begin
          srch_done = 1'b1;
          restamp_nxt = 1'b1; setref_nxt = 1'b0;
          if (!a_ok_nxt) begin
            oout_nxt = OUT_FAIL; oidx_nxt = '0; srch_to = ST_DONE;
          end else begin
            srch_to = ST_REPL_RD;
            if (policy == POL_PLRU) idx_nxt = o_ok_nxt ? o_idx_nxt : s_idx_nxt;
            else                    idx_nxt = a_idx_nxt;
          end
        end
      end
      ST_REPL_RD: begin
        req.rd_en = 1'b1; req.rd_addr = idx_r;
      end
      ST_REPL_WR: begin
        req.wr_en = 1'b1; req.wr_addr = idx_r;
        req.wr_data.owner = pid_r; req.wr_data.page = pg_r;
        req.wr_data.touched = 1'b0;
        if (setref_r) req.wr_data.refbit = 1'b1;
        if (restamp_r) begin
          req.wr_data.stamp = cnt_r; cnt_nxt = cnt_inc;
        end
        oout_nxt = OUT_REPLACE; oidx_nxt = idx_r;
      end
      ST_DONE: ovalid_nxt = 1'b1;
      default: ;
    endcase
    if (state_r == ST_DECIDE) s_st_nxt = '0;
  end

  assign in_ready        = (state_r == ST_IDLE) && !ovalid_r;
  assign out_valid       = ovalid_r;
  assign out_outcome     = oout_r;
  assign out_frame_index = 6'(oidx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; fifo_r <= '0; clk_r <= '0; cnt_r <= '0;
      ovalid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; fifo_r <= fifo_nxt;
      clk_r <= clk_nxt; cnt_r <= cnt_nxt; ovalid_r <= ovalid_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pid_r <= in_process_id; pg_r <= in_page_number;
      m_r <= m_c;
      live_r <= (fill_r < m_c) ? fill_r : m_c;
    end
    i_r <= i_nxt; g_r <= g_nxt; hit_r <= hit_nxt; idx_r <= idx_nxt; pa_r <= pa_nxt;
    a_ok_r <= a_ok_nxt; a_idx_r <= a_idx_nxt; a_st_r <= a_st_nxt;
    o_ok_r <= o_ok_nxt; o_idx_r <= o_idx_nxt; o_st_r <= o_st_nxt;
    s_ok_r <= s_ok_nxt; s_idx_r <= s_idx_nxt; s_st_r <= s_st_nxt;
    oout_r <= oout_nxt; oidx_r <= oidx_nxt;
    restamp_r <= restamp_nxt; setref_r <= setref_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/page_replacement_engine_unit.sv =====
// ----------------------------------------------------------------------------
// page_replacement_engine_unit: page replacement engine
// frame lookup, fill and victim replacement over a frame record memory
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  in_     | input     | process id, page number
//  out_    | output    | outcome, frame index
//  cfg_    | apb       | policy (0x0), frames in use (0x4)
//
// a hit or a fill scans the L resident frames before out_valid; a replacement
// adds a victim search over the M managed frames (fifo, lru, second chance);
// one memory read per cycle sets the pace; rst_n is synchronous and clears
// the state, counters, pointers and config registers only, frame records need
// no clearing; a stalled result holds the engine idle until taken
`default_nettype none
module page_replacement_engine_unit
  import pre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_process_id,
  input  wire logic [15:0] in_page_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_outcome,
  output logic [5:0]       out_frame_index,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  policy_t    policy_r;
  logic [6:0] frames_r;
  mem_req_t   req;
  frame_t     rd_data;
  logic       wr_c;
  logic [1:0] ridx_c;

  assign cfg_pready = 1'b1;
  assign wr_c = cfg_psel && cfg_penable && cfg_pwrite;
  // registers sit on word addresses
  assign ridx_c = {1'b0, cfg_paddr[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIFO;
      frames_r <= 7'd64;
    end else if (wr_c) begin
      if (ridx_c == REG_POLICY) policy_r <= policy_t'(cfg_pwdata[1:0]);
      if (ridx_c == REG_FRAMES) frames_r <= cfg_pwdata[6:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (ridx_c == REG_POLICY) cfg_prdata = {30'd0, policy_r};
    else if (ridx_c == REG_FRAMES) cfg_prdata = {25'd0, frames_r};
  end

  pre_seq u_seq (
    .clk, .rst_n, .policy(policy_r), .frames_cfg(frames_r),
    .in_valid, .in_ready, .in_process_id, .in_page_number,
    .out_valid, .out_ready, .out_outcome, .out_frame_index,
    .req, .rd_data
  );

  pre_frame_ram u_ram (.clk, .req, .rd_data);
endmodule
`default_nettype wire

// ===== rtl/pre_checker.sv =====
// ----------------------------------------------------------------------------
// pre_checker: port-level checks for the page replacement engine
// ----------------------------------------------------------------------------
`default_nettype none
module pre_checker
  import pre_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_outcome,
  input wire logic [5:0] out_frame_index
);
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_FAIL |-> out_frame_index == 6'd0)
    else $error("failed beat carries nonzero frame");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second access taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("result beat dropped");
  a_no_take_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("access taken while result pending");
endmodule

bind page_replacement_engine_unit pre_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_outcome, .out_frame_index
);
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: page replacement engine testbench
// drives page accesses through every policy and a range of frame counts, predicts each
// outcome and frame index from a behavioural frame table and checks each beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb
  import pre_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_process_id = '0;
  logic [15:0] in_page_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_outcome;
  logic [5:0]  out_frame_index;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_replacement_engine_unit DUT (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0] outcome;
    logic [5:0] frame;
  } access_result_t;

  // predicted frame table
  logic [7:0]            tbl_owner   [FRAMES];
  logic [15:0]           tbl_page    [FRAMES];
  logic [STAMP_BITS-1:0] tbl_stamp   [FRAMES];
  logic                  tbl_refbit  [FRAMES];
  logic                  tbl_touched [FRAMES];
  int unsigned           fill_cnt, fifo_ptr, clock_ptr;
  logic [STAMP_BITS-1:0] stamp_cnt;
  policy_t               cur_policy;
  logic [6:0]            cur_frames;

  access_result_t pending_results[$];
  int  fail_count = 0;
  longint cycles = 0;
  int  results_seen = 0;
  int  long_gap_pct = 5;

  function automatic logic [STAMP_BITS-1:0] next_stamp();
    logic [STAMP_BITS-1:0] s;
    s = stamp_cnt;
    if (stamp_cnt != STAMP_MAX) stamp_cnt++;
    return s;
  endfunction

  function automatic void load_frame(int unsigned f, logic [7:0] pid, logic [15:0] pg);
    tbl_owner[f] = pid;
    tbl_page[f] = pg;
    tbl_touched[f] = 1'b0;
  endfunction

  function automatic int unsigned pick_lru(int unsigned m, logic [7:0] pid, bit aware);
    int unsigned v;
    bit found;
    found = 0;
    v = m;
    if (!aware) begin
      for (int unsigned k = 0; k < m; k++)
        if (tbl_touched[k] && (!found || tbl_stamp[k] < tbl_stamp[v])) begin
          v = k; found = 1;
        end
      return v;
    end
    for (int unsigned k = 0; k < m; k++)
      if (tbl_touched[k] && tbl_owner[k] != pid &&
          (!found || tbl_stamp[k] < tbl_stamp[v])) begin
        v = k; found = 1;
      end
    if (found) return v;
    // only the requester's frames left: take its most recent
    for (int unsigned k = 0; k < m; k++)
      if (tbl_touched[k] && (!found || tbl_stamp[k] > tbl_stamp[v])) begin
        v = k; found = 1;
      end
    return v;
  endfunction

  function automatic access_result_t predict_access(logic [7:0] pid, logic [15:0] pg);
    access_result_t r;
    int unsigned m, live, v, d, g, s;
    bit hit, failed;
    m = (cur_frames < 1) ? 1 : (cur_frames > FRAMES ? FRAMES : cur_frames);
    live = fill_cnt < m ? fill_cnt : m;
    hit = 0;
    r.frame = '0;
    for (int unsigned i = 0; i < live; i++)
      if (tbl_owner[i] == pid && tbl_page[i] == pg) begin
        tbl_stamp[i] = next_stamp();
        tbl_refbit[i] = 1'b1;
        tbl_touched[i] = 1'b1;
        if (!hit) r.frame = i[5:0];
        hit = 1;
      end
    if (hit) begin
      r.outcome = OUT_HIT;
      return r;
    end
    if (fill_cnt < m) begin
      r.frame = fill_cnt[5:0];
      load_frame(fill_cnt, pid, pg);
      tbl_stamp[fill_cnt] = next_stamp();
      tbl_refbit[fill_cnt] = 1'b1;
      fill_cnt++;
      r.outcome = OUT_LOAD;
      return r;
    end
    v = m;
    if (fifo_ptr >= m) fifo_ptr = 0;
    if (clock_ptr >= m) clock_ptr = 0;
    case (cur_policy)
      POL_FIFO: begin
        d = 0;
        while (!tbl_touched[fifo_ptr]) begin
          fifo_ptr = (fifo_ptr + 1) % m;
          d++;
          if (d == m) break;
        end
        if (d < m) begin
          v = fifo_ptr;
          load_frame(v, pid, pg);
          fifo_ptr = (fifo_ptr + 1) % m;
        end
      end
      POL_CLOCK: begin
        g = 0; s = 0; failed = 0;
        while (tbl_refbit[clock_ptr] || !tbl_touched[clock_ptr]) begin
          g++;
          tbl_refbit[clock_ptr] = 1'b0;
          if (!tbl_touched[clock_ptr]) s++;
          if (g == m && s == g) begin
            failed = 1;
            break;
          end
          clock_ptr = (clock_ptr + 1) % m;
        end
        if (!failed) begin
          v = clock_ptr;
          load_frame(v, pid, pg);
          tbl_refbit[v] = 1'b1;
          clock_ptr = (clock_ptr + 1) % m;
        end
      end
      default: begin
        v = pick_lru(m, pid, cur_policy == POL_PLRU);
        if (v < m) begin
          load_frame(v, pid, pg);
          tbl_stamp[v] = next_stamp();
        end
      end
    endcase
    if (v < m) begin
      r.outcome = OUT_REPLACE;
      r.frame = v[5:0];
    end else begin
      r.outcome = OUT_FAIL;
      r.frame = '0;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(99) < long_gap_pct) return $urandom_range(60, 15);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3, 1);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, checks each beat against the oldest prediction
  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result beat outcome %0d frame %0d", out_outcome, out_frame_index);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_outcome !== exp_r.outcome) begin
            $error("outcome: expected %0d, actual %0d", exp_r.outcome, out_outcome);
            fail_count++;
          end
          if (out_frame_index !== exp_r.frame) begin
            $error("frame_index: expected %0d, actual %0d", exp_r.frame, out_frame_index);
            fail_count++;
          end
        end
      end
      out_ready <= (gap_len() == 0);
    end
  end

  // valid stays up across back-to-back beats, drops only before a gap
  task automatic send_access(logic [7:0] pid, logic [15:0] pg);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_process_id <= pid;
    in_page_number <= pg;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_access(pid, pg));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx[0], 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_POLICY) cur_policy = policy_t'(val[1:0]);
    else cur_frames = val[6:0];
    @(posedge clk);
  endtask

  // a working set over a few processes; hits touch frames so they can be evicted
  task automatic run_workload(int unsigned n, int unsigned pids, int unsigned pages);
    logic [7:0] pid;
    logic [15:0] pg;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        pid = 8'($urandom);
        pg = 16'($urandom);
      end else begin
        pid = 8'($urandom_range(pids - 1)) ^ 8'hA5;
        pg = 16'($urandom_range(pages - 1)) ^ 16'h5A3C;
      end
      send_access(pid, pg);
    end
  endtask

  task automatic test_directed_fill();
    // fill two frames, all pinned, then a miss fails; hits unpin both and later misses replace them
    write_reg(REG_FRAMES, 32'd2);
    write_reg(REG_POLICY, 32'(POL_FIFO));
    send_access(8'h00, 16'h0000);
    send_access(8'hFF, 16'hFFFF);
    send_access(8'h01, 16'h1234);
    send_access(8'h00, 16'h0000);
    send_access(8'hFF, 16'hFFFF);
    send_access(8'hFF, 16'hFFFF);
    send_access(8'h55, 16'hAAAA);
    send_access(8'hAA, 16'h5555);
    drain();
  endtask

  task automatic test_directed_policies();
    policy_t p;
    for (int k = 0; k < 4; k++) begin
      p = policy_t'(k);
      write_reg(REG_POLICY, 32'(p));
      send_access(8'h00, 16'h0000);
      send_access(8'hFF, 16'hFFFF);
      send_access(8'h00, 16'h0000);
      send_access(8'h07, 16'h00F0);
    end
    drain();
    // frame count zero acts as one, over range acts as the full table
    write_reg(REG_FRAMES, 32'd0);
    send_access(8'h12, 16'h3456);
    send_access(8'h12, 16'h3456);
    drain();
    write_reg(REG_FRAMES, 32'd127);
    send_access(8'h12, 16'h3456);
    drain();
  endtask

  task automatic test_random_settings();
    int unsigned fr_opts[6] = '{1, 2, 7, 16, 33, 64};
    for (int ph = 0; ph < 24; ph++) begin
      write_reg(REG_POLICY, 32'($urandom_range(3)));
      write_reg(REG_FRAMES, 32'(fr_opts[$urandom_range(5)]));
      long_gap_pct = (ph % 4 == 0) ? 0 : 5;
      run_workload(66, $urandom_range(6, 1), $urandom_range(80, 2));
      if (ph % 6 == 5) drain();
    end
    drain();
  endtask

  initial begin
    cur_policy = POL_FIFO;
    cur_frames = 7'd64;
    fill_cnt = 0; fifo_ptr = 0; clock_ptr = 0;
    stamp_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fill();
    test_directed_policies();
    test_random_settings();
    $display("covered all four policies, frame counts 0 to 127 and %0d checked accesses",
             results_seen);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
